// ===== rtl/gcr62_pkg.sv =====
// Shared types, constants and lookup tables for the 6-and-2 GCR sector decoder.
// No dependencies; used by every module under rtl/.
package gcr62_pkg;

  localparam int ADDR_BITS = 16;
  localparam int AddrW     = 16;
  localparam int PosW      = 9;
  localparam int AuxIdxW   = 7;
  localparam int AuxW      = 6;

  localparam logic [AddrW-1:0] AddrMask =
    (ADDR_BITS >= AddrW) ? {AddrW{1'b1}} : AddrW'((64'd1 << ADDR_BITS) - 64'd1);

  localparam logic [PosW-1:0] PosIdle   = 9'h1FF;
  localparam logic [PosW-1:0] ProEnd    = 9'd3;
  localparam logic [PosW-1:0] DataFirst = 9'd9;
  localparam logic [PosW-1:0] DataEnd   = 9'd351;
  localparam logic [PosW-1:0] EpiFirst  = 9'd352;
  localparam logic [PosW-1:0] FrameLast = 9'd354;
  localparam logic [PosW-1:0] HighFirst = 9'd95;
  localparam logic [7:0]      AuxCount  = 8'd86;
  localparam logic [7:0]      AuxCount2 = 8'd172;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    GRP_LO  = 2'd0,
    GRP_MID = 2'd1,
    GRP_HI  = 2'd2
  } grp_t;

  typedef struct packed {
    kind_t            kind;
    logic [AddrW-1:0] addr;
    logic [5:0]       xor_hi;
    grp_t             grp;
  } s1_t;

  localparam logic [7:0] NibMap [128] = '{
    8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
    8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
    8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'h00,8'h04,
    8'hff,8'hff,8'h08,8'h0c,8'hff,8'h10,8'h14,8'h18,
    8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'h1c,8'h20,
    8'hff,8'hff,8'hff,8'h24,8'h28,8'h2c,8'h30,8'h34,
    8'hff,8'hff,8'h38,8'h3c,8'h40,8'h44,8'h48,8'h4c,
    8'hff,8'h50,8'h54,8'h58,8'h5c,8'h60,8'h64,8'h68,
    8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
    8'hff,8'hff,8'hff,8'h6c,8'hff,8'h70,8'h74,8'h78,
    8'hff,8'hff,8'hff,8'h7c,8'hff,8'hff,8'h80,8'h84,
    8'hff,8'h88,8'h8c,8'h90,8'h94,8'h98,8'h9c,8'ha0,
    8'hff,8'hff,8'hff,8'hff,8'hff,8'ha4,8'ha8,8'hac,
    8'hff,8'hb0,8'hb4,8'hb8,8'hbc,8'hc0,8'hc4,8'hc8,
    8'hff,8'hff,8'hcc,8'hd0,8'hd4,8'hd8,8'hdc,8'he0,
    8'hff,8'he4,8'he8,8'hec,8'hf0,8'hf4,8'hf8,8'hfc
  };

  function automatic logic [7:0] pro_mark(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'hd5;
      2'd1:    m = 8'haa;
      default: m = 8'had;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] epi_mark(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'hde;
      2'd1:    m = 8'haa;
      default: m = 8'heb;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/gcr62_aux_ram.sv =====
// Auxiliary two-bit group store: 86 x 6 bits, one write and one read port.
// Read data is registered. Depends on gcr62_pkg.
module gcr62_aux_ram (
  input  logic                             clk,
  input  logic                             we,
  input  logic [gcr62_pkg::AuxIdxW-1:0]    waddr,
  input  logic [gcr62_pkg::AuxW-1:0]       wdata,
  input  logic                             re,
  input  logic [gcr62_pkg::AuxIdxW-1:0]    raddr,
  output logic [gcr62_pkg::AuxW-1:0]       rdata_r
);

  logic [gcr62_pkg::AuxW-1:0] mem [86];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== rtl/gcr62_ctrl.sv =====
// Frame sequencer: position tracking, marker checks, XOR chain, aux store access.
// Drives the request stage that feeds gcr62_out. Depends on gcr62_pkg, gcr62_aux_ram.
module gcr62_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [15:0]                  cfg_wr_data,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   raw_byte,
  input  logic                         frame_start,
  input  logic                         s1_ready,
  output logic                         s1_valid_r,
  output gcr62_pkg::s1_t               s1_r,
  output logic [gcr62_pkg::AuxW-1:0]   aux_rdata
);

  logic [15:0]                   dest_r;
  logic [gcr62_pkg::PosW-1:0]    pos_r, pos_nxt, pos_eff;
  logic [7:0]                    xor_r, xor_nxt, xor_base, xor_new;
  logic                          epi_r, epi_nxt, epi_base;
  logic                          s1_valid_nxt;
  gcr62_pkg::s1_t                s1_nxt;
  logic                          accept, active, emit;
  logic [gcr62_pkg::PosW-1:0]    k_w, j_w;
  logic [7:0]                    j, jm;
  logic                          ram_we, ram_re;
  logic [gcr62_pkg::AuxIdxW-1:0] ram_waddr, ram_raddr;
  logic [gcr62_pkg::AuxW-1:0]    ram_wdata;
  logic [gcr62_pkg::PosW-1:0]    epi_idx;

  assign in_tready = !s1_valid_r || s1_ready;
  assign accept    = in_tvalid && in_tready;
  assign active    = frame_start || (pos_r != gcr62_pkg::PosIdle);
  assign pos_eff   = frame_start ? '0 : pos_r;
  assign xor_base  = frame_start ? 8'h00 : xor_r;
  assign epi_base  = frame_start ? 1'b1 : epi_r;
  assign xor_new   = xor_base ^ gcr62_pkg::NibMap[raw_byte[6:0]];
  assign k_w       = pos_eff - gcr62_pkg::DataFirst;
  assign j_w       = pos_eff - gcr62_pkg::HighFirst;
  assign j         = j_w[7:0];
  assign epi_idx   = pos_eff - gcr62_pkg::EpiFirst;

  always_comb begin
    if (j < gcr62_pkg::AuxCount) begin
      jm = j;
    end else if (j < gcr62_pkg::AuxCount2) begin
      jm = j - gcr62_pkg::AuxCount;
    end else begin
      jm = j - gcr62_pkg::AuxCount2;
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    xor_nxt   = xor_r;
    epi_nxt   = epi_r;
    emit      = 1'b0;
    s1_nxt    = '{kind: gcr62_pkg::KIND_BAD, addr: '0, xor_hi: '0, grp: gcr62_pkg::GRP_LO};
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = k_w[gcr62_pkg::AuxIdxW-1:0];
    ram_wdata = xor_new[7:2];
    ram_raddr = jm[gcr62_pkg::AuxIdxW-1:0];
    if (accept && active) begin
      pos_nxt = pos_eff + 9'd1;
      xor_nxt = xor_base;
      epi_nxt = epi_base;
      if (pos_eff < gcr62_pkg::ProEnd) begin
        if (raw_byte != gcr62_pkg::pro_mark(pos_eff[1:0])) begin
          emit    = 1'b1;
          pos_nxt = gcr62_pkg::PosIdle;
        end
      end else if (pos_eff < gcr62_pkg::DataFirst) begin
        pos_nxt = pos_eff + 9'd1;
      end else if (pos_eff < gcr62_pkg::DataEnd) begin
        xor_nxt = xor_new;
        if (k_w < {1'b0, gcr62_pkg::AuxCount}) begin
          ram_we = 1'b1;
        end else begin
          ram_re        = 1'b1;
          emit          = 1'b1;
          s1_nxt.kind   = gcr62_pkg::KIND_DATA;
          s1_nxt.addr   = (dest_r + {8'h00, j}) & gcr62_pkg::AddrMask;
          s1_nxt.xor_hi = xor_new[7:2];
          if (j < gcr62_pkg::AuxCount) begin
            s1_nxt.grp = gcr62_pkg::GRP_LO;
          end else if (j < gcr62_pkg::AuxCount2) begin
            s1_nxt.grp = gcr62_pkg::GRP_MID;
          end else begin
            s1_nxt.grp = gcr62_pkg::GRP_HI;
          end
        end
      end else if (pos_eff < gcr62_pkg::EpiFirst) begin
        pos_nxt = pos_eff + 9'd1;
      end else if (pos_eff <= gcr62_pkg::FrameLast) begin
        epi_nxt = epi_base && (raw_byte == gcr62_pkg::epi_mark(epi_idx[1:0]));
        if (pos_eff == gcr62_pkg::FrameLast) begin
          emit        = 1'b1;
          pos_nxt     = gcr62_pkg::PosIdle;
          s1_nxt.kind = epi_nxt ? gcr62_pkg::KIND_OK : gcr62_pkg::KIND_BAD;
        end
      end else begin
        pos_nxt = gcr62_pkg::PosIdle;
      end
    end
  end

  always_comb begin
    if (accept && emit) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_ready) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_r     <= '0;
      pos_r      <= gcr62_pkg::PosIdle;
      xor_r      <= '0;
      epi_r      <= 1'b1;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        dest_r <= cfg_wr_data;
      end
      pos_r      <= pos_nxt;
      xor_r      <= xor_nxt;
      epi_r      <= epi_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      s1_r <= s1_nxt;
    end
  end

  gcr62_aux_ram u_aux_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (aux_rdata)
  );

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r <= gcr62_pkg::FrameLast) || (pos_r == gcr62_pkg::PosIdle))
    else $error("frame position out of range");

  a_ram_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("aux store written and read in one cycle");

  a_no_accept_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_ready) |=> ($stable(s1_r) && s1_valid_r))
    else $error("request stage lost while stalled");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (s1_r.kind == gcr62_pkg::KIND_DATA || s1_r.kind == gcr62_pkg::KIND_OK ||
                    s1_r.kind == gcr62_pkg::KIND_BAD))
    else $error("illegal request kind");

endmodule

// ===== rtl/gcr62_out.sv =====
// Output stage: merges aux store data with the chained high bits, holds the result.
// Depends on gcr62_pkg.
module gcr62_out (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         s1_valid,
  input  gcr62_pkg::s1_t               s1,
  input  logic [gcr62_pkg::AuxW-1:0]   aux_rdata,
  output logic                         s1_ready,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [1:0]                   out_kind,
  output logic [gcr62_pkg::AddrW-1:0]  out_addr,
  output logic [7:0]                   out_byte
);

  logic                          o_valid_r, o_valid_nxt;
  logic [1:0]                    o_kind_r;
  logic [gcr62_pkg::AddrW-1:0]   o_addr_r;
  logic [7:0]                    o_byte_r, byte_nxt;
  logic [1:0]                    pair;
  logic                          load;

  assign s1_ready = !o_valid_r || out_tready;
  assign load     = s1_valid && s1_ready;

  always_comb begin
    case (s1.grp)
      gcr62_pkg::GRP_LO:  pair = aux_rdata[1:0];
      gcr62_pkg::GRP_MID: pair = aux_rdata[3:2];
      default:            pair = aux_rdata[5:4];
    endcase
    if (s1.kind == gcr62_pkg::KIND_DATA) begin
      byte_nxt = {s1.xor_hi, pair[0], pair[1]};
    end else begin
      byte_nxt = 8'h00;
    end
  end

  always_comb begin
    if (load) begin
      o_valid_nxt = 1'b1;
    end else if (out_tready) begin
      o_valid_nxt = 1'b0;
    end else begin
      o_valid_nxt = o_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else begin
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_kind_r <= s1.kind;
      o_addr_r <= s1.addr;
      o_byte_r <= byte_nxt;
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_kind   = o_kind_r;
  assign out_addr   = o_addr_r;
  assign out_byte   = o_byte_r;

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_kind_r != gcr62_pkg::KIND_DATA) |-> (o_addr_r == '0 && o_byte_r == 8'h00))
    else $error("status result carries data");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && !out_tready) |=> (o_valid_r && $stable(o_byte_r) && $stable(o_addr_r)))
    else $error("result dropped while stalled");

endmodule

// ===== rtl/gcr_6and2_sector_decoder_top.sv =====
// Channel  | direction | tdata                         | tuser
// in_      | sink      | [7:0] raw_byte                | [0] frame_start
// out_     | source    | [15:0] out_addr, [23:16] byte | [1:0] kind
// cfg_     | write     | cfg_wr_data[15:0] dest_offset | -
// One request per cycle while the result side is ready; each request passes the
// request stage and the output register. The registered aux read sets the depth.
// Reset is synchronous, active low; the aux store needs no clearing.
// A stalled result holds in the output register; in_tready drops only when both
// the request stage and the output register are full.
module gcr_6and2_sector_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] raw_byte
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] out_addr, [23:16] out_byte
  output logic [1:0]  out_tuser   // [1:0] kind
);

  logic                        s1_valid, s1_ready;
  gcr62_pkg::s1_t              s1;
  logic [gcr62_pkg::AuxW-1:0]  aux_rdata;
  logic [1:0]                  kind;
  logic [15:0]                 addr;
  logic [7:0]                  data_byte;

  gcr62_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .raw_byte    (in_tdata),
    .frame_start (in_tuser),
    .s1_ready    (s1_ready),
    .s1_valid_r  (s1_valid),
    .s1_r        (s1),
    .aux_rdata   (aux_rdata)
  );

  gcr62_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .aux_rdata  (aux_rdata),
    .s1_ready   (s1_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_kind   (kind),
    .out_addr   (addr),
    .out_byte   (data_byte)
  );

  assign out_tdata = {data_byte, addr};
  assign out_tuser = kind;

endmodule
